// File: hw/rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared types, constants and date arithmetic helpers.
// ----------------------------------------------------------------------------
package cal_pkg;

    // command codes, carried on the input tuser
    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_SPARE   = 2'd3
    } cmd_t;

    // one calendar date
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // one input item
    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
    } item_t;

    localparam logic [13:0] YEAR_MIN    = 14'd1;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [13:0] YEAR_RESET  = 14'd2000;
    localparam logic [13:0] SWITCH_YEAR = 14'd1916;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_APR   = 4'd4;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [3:0]  MONTH_WRAP  = 4'd12;
    localparam logic [4:0]  DAY_ONE     = 5'd1;
    localparam logic [4:0]  SWITCH_DAY  = 5'd14;
    localparam logic [4:0]  DAY_LAST    = 5'd31;

    // reciprocal of 25 scaled by 2^18, exact floor for inputs below 43690
    localparam logic [27:0] RECIP25     = 28'd10486;
    localparam int          RECIP25_SH  = 18;

    localparam date_t DATE_RESET = '{year: YEAR_RESET, month: MONTH_JAN, day: DAY_ONE};

    // floor(y / 25) by multiply and shift
    function automatic logic [9:0] div25(input logic [13:0] y);
        logic [27:0] prod;
        prod = {14'd0, y} * RECIP25;
        return prod[RECIP25_SH +: 10];
    endfunction

    // y is a multiple of 25
    function automatic logic is_mult25(input logic [13:0] y);
        logic [9:0]  q;
        logic [13:0] back;
        q    = div25(y);
        back = {q, 4'd0} + {1'b0, q, 3'd0} + {4'd0, q};
        return back == y;
    endfunction

    // julian rule up to the switch year, gregorian after
    function automatic logic leap_year(input logic [13:0] y);
        logic by4;
        by4 = (y[1:0] == 2'd0);
        if (y <= SWITCH_YEAR)
            return by4;
        return by4 && (!is_mult25(y) || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] len;
        unique case (m)
            4'd2:                   len = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (m + 1) / 5) for the shifted months 3..14
    function automatic logic [5:0] zeller_month_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// File: hw/rtl/cal_date_update.sv
// ----------------------------------------------------------------------------
// Calendar date update stage
// Holds the current date and applies set, advance or read for each item.
// ----------------------------------------------------------------------------
module cal_date_update (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cal_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output cal_pkg::date_t  out_date
);

    cal_pkg::date_t date_reg;
    cal_pkg::date_t date_next;
    logic           vld_reg;
    logic           vld_next;
    logic           fire;

    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_len;
    logic [4:0]  set_day_chk;
    logic [4:0]  set_day;
    logic [4:0]  cur_len;

    // stage handshake
    assign in_ready  = !vld_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_date  = date_reg;

    // set path: clamp year, fix month and day, then the april gap
    always_comb
    begin
        if (in_item.new_year == 14'd0)
            set_year = cal_pkg::YEAR_MIN;
        else if (in_item.new_year > cal_pkg::YEAR_MAX)
            set_year = cal_pkg::YEAR_MAX;
        else
            set_year = in_item.new_year;

        if (in_item.new_month == 4'd0 || in_item.new_month > cal_pkg::MONTH_DEC)
            set_month = cal_pkg::MONTH_JAN;
        else
            set_month = in_item.new_month;

        set_len = cal_pkg::month_length(set_month, set_year);

        if (in_item.new_day == 5'd0 || in_item.new_day > set_len)
            set_day_chk = cal_pkg::DAY_ONE;
        else
            set_day_chk = in_item.new_day;

        if (set_year == cal_pkg::SWITCH_YEAR && set_month == cal_pkg::MONTH_APR
            && set_day_chk < cal_pkg::SWITCH_DAY)
            set_day = cal_pkg::SWITCH_DAY;
        else
            set_day = set_day_chk;
    end

    // next date
    always_comb
    begin
        cur_len   = cal_pkg::month_length(date_reg.month, date_reg.year);
        date_next = date_reg;
        unique case (in_item.cmd)
            cal_pkg::CMD_SET:
            begin
                date_next.year  = set_year;
                date_next.month = set_month;
                date_next.day   = set_day;
            end
            cal_pkg::CMD_ADVANCE:
            begin
                priority if (date_reg.year == cal_pkg::SWITCH_YEAR
                             && date_reg.month == cal_pkg::MONTH_MAR
                             && date_reg.day == cal_pkg::DAY_LAST)
                begin
                    date_next.day   = cal_pkg::SWITCH_DAY;
                    date_next.month = cal_pkg::MONTH_APR;
                end
                else if (date_reg.day < cur_len)
                begin
                    date_next.day = date_reg.day + 5'd1;
                end
                else if (date_reg.month < cal_pkg::MONTH_DEC)
                begin
                    date_next.day   = cal_pkg::DAY_ONE;
                    date_next.month = date_reg.month + 4'd1;
                end
                else if (date_reg.year < cal_pkg::YEAR_MAX)
                begin
                    date_next.day   = cal_pkg::DAY_ONE;
                    date_next.month = cal_pkg::MONTH_JAN;
                    date_next.year  = date_reg.year + 14'd1;
                end
                else
                begin
                    date_next = date_reg;
                end
            end
            default:
            begin
                date_next = date_reg;
            end
        endcase
    end

    // valid flag
    always_comb
    begin
        if (fire)
            vld_next = 1'b1;
        else if (out_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    // date and valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg <= cal_pkg::DATE_RESET;
            vld_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (fire)
                date_reg <= date_next;
        end
    end

    // the date only changes when an item enters
    a_date_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(date_reg))
        else $error("date changed without an item");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_reg.month != 4'd0 && date_reg.month <= cal_pkg::MONTH_DEC)
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_reg.day != 5'd0
        && date_reg.day <= cal_pkg::month_length(date_reg.month, date_reg.year))
        else $error("day out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_reg.year != 14'd0 && date_reg.year <= cal_pkg::YEAR_MAX)
        else $error("year out of range");

endmodule

// File: hw/rtl/cal_weekday.sv
// ----------------------------------------------------------------------------
// Calendar weekday stages
// Zeller sum in one stage, mod 7 and result register in the next.
// ----------------------------------------------------------------------------
module cal_weekday (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cal_pkg::date_t  in_date,
    output logic            out_valid,
    input  logic            out_ready,
    output cal_pkg::date_t  out_date,
    output logic [2:0]      out_weekday
);

    logic           s3_vld_reg;
    logic           s3_vld_next;
    cal_pkg::date_t s3_date_reg;
    logic [14:0]    s3_sum_reg;
    logic [14:0]    s3_sum_next;
    logic           out_vld_reg;
    logic           out_vld_next;
    cal_pkg::date_t out_date_reg;
    logic [2:0]     out_wd_reg;
    logic [2:0]     out_wd_next;

    logic        s3_ready;
    logic        s4_ready;
    logic        s3_fire;
    logic        s4_fire;

    logic [3:0]  zm;
    logic [13:0] zy;
    logic [11:0] zy4;
    logic [9:0]  zy100;
    logic [9:0]  zy400;

    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  rem7;

    // stage handshake
    assign s4_ready    = !out_vld_reg || out_ready;
    assign s3_ready    = !s3_vld_reg || s4_ready;
    assign in_ready    = s3_ready;
    assign s3_fire     = in_valid && s3_ready;
    assign s4_fire     = s3_vld_reg && s4_ready;
    assign out_valid   = out_vld_reg;
    assign out_date    = out_date_reg;
    assign out_weekday = out_wd_reg;

    // zeller sum: jan and feb count as months 13 and 14 of the year before
    always_comb
    begin
        if (in_date.month < cal_pkg::MONTH_MAR)
        begin
            zm = in_date.month + 4'd12;
            zy = in_date.year - 14'd1;
        end
        else
        begin
            zm = in_date.month;
            zy = in_date.year;
        end
        zy4   = zy[13:2];
        zy100 = cal_pkg::div25({2'd0, zy4});
        zy400 = cal_pkg::div25({4'd0, zy[13:4]});
        s3_sum_next = {10'd0, in_date.day} + {9'd0, cal_pkg::zeller_month_term(zm)}
                    + {1'b0, zy} + {3'd0, zy4} + {5'd0, zy400} - {5'd0, zy100};
    end

    // sum mod 7 by folding octal digits, then shift so monday is 1
    always_comb
    begin
        fold1 = {3'd0, s3_sum_reg[2:0]} + {3'd0, s3_sum_reg[5:3]}
              + {3'd0, s3_sum_reg[8:6]} + {3'd0, s3_sum_reg[11:9]}
              + {3'd0, s3_sum_reg[14:12]};
        fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
        if (fold2 >= 4'd7)
            rem7 = 3'(fold2 - 4'd7);
        else
            rem7 = fold2[2:0];
        if (rem7 >= 3'd2)
            out_wd_next = rem7 - 3'd1;
        else
            out_wd_next = rem7 + 3'd6;
    end

    // valid flags
    always_comb
    begin
        if (s3_fire)
            s3_vld_next = 1'b1;
        else if (s4_ready)
            s3_vld_next = 1'b0;
        else
            s3_vld_next = s3_vld_reg;

        if (s4_fire)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s3_fire)
        begin
            s3_date_reg <= in_date;
            s3_sum_reg  <= s3_sum_next;
        end
        if (s4_fire)
        begin
            out_date_reg <= s3_date_reg;
            out_wd_reg   <= out_wd_next;
        end
    end

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_wd_reg != 3'd0))
        else $error("weekday out of range");

    a_date_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s4_fire |=> (out_date_reg == $past(s3_date_reg)))
        else $error("date lost between stages");

endmodule

// File: hw/rtl/calendar_date_counter_top.sv
// ----------------------------------------------------------------------------
// Calendar date counter
// Keeps a date and returns it with its weekday after every command.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per command. tuser carries the command
// (set date, advance one day, read; the spare code reads), tdata carries
// the day, month and year used by a set command.
// Output channel m_*: one item per command with the date after the command
// and its weekday, 1 for Monday through 7 for Sunday.
// Path: an accepted item passes the input register, date register, Zeller
// sum register and result register before m_tvalid rises.
// Throughput: one item per cycle while m_tready is high; the date update is a
// loop around the date register and the weekday follows in two more stages.
// Reset: the date returns to 1.1.2000 and all stages empty.
// Stall: while m_tready is low the result holds; the stages behind it keep
// filling, and s_tready drops only once all four stages hold an item.
// ----------------------------------------------------------------------------
module calendar_date_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // new_day[4:0], new_month[8:5], new_year[22:9], zero
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                   // weekday[25:23], zero
);

    logic            in_vld_reg;
    logic            in_vld_next;
    cal_pkg::item_t  in_item_reg;
    logic            s_fire;

    logic            upd_ready;
    logic            upd_valid;
    cal_pkg::date_t  upd_date;
    logic            wd_ready;
    cal_pkg::date_t  res_date;
    logic [2:0]      res_weekday;

    // input register handshake
    assign s_tready = !in_vld_reg || upd_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        if (s_fire)
            in_vld_next = 1'b1;
        else if (upd_ready)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.cmd       <= cal_pkg::cmd_t'(s_tuser);
            in_item_reg.new_day   <= s_tdata[4:0];
            in_item_reg.new_month <= s_tdata[8:5];
            in_item_reg.new_year  <= s_tdata[22:9];
        end
    end

    // date state and command
    cal_date_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .in_ready  (upd_ready),
        .in_item   (in_item_reg),
        .out_valid (upd_valid),
        .out_ready (wd_ready),
        .out_date  (upd_date)
    );

    // weekday and result register
    cal_weekday u_weekday (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (upd_valid),
        .in_ready    (wd_ready),
        .in_date     (upd_date),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_date    (res_date),
        .out_weekday (res_weekday)
    );

    // pack result
    assign m_tdata = {6'd0, res_weekday, res_date.year, res_date.month, res_date.day};

endmodule

// File: tb/sv/cal_date_checker.sv
// ----------------------------------------------------------------------------
// Calendar date checker
// Watches both stream channels of the date counter and keeps its own copy of
// the date. Every accepted command updates that copy and queues the date and
// weekday that must come back. Every accepted result is compared field by
// field against the oldest queued entry.
// ----------------------------------------------------------------------------
module cal_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // new_day[4:0], new_month[8:5], new_year[22:9], zero
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                   // weekday[25:23], zero
    output int          errors,
    output int          pending,
    output int          checked,
    output int          switch_hits,
    output int          saturate_hits
);

    typedef struct {
        cal_pkg::date_t dt;
        logic [2:0]     wd;
    } date_result_t;

    cal_pkg::date_t cur_date = cal_pkg::DATE_RESET;
    date_result_t   expected_dates[$];

    // julian rule up to the switch year, gregorian after it
    function automatic bit is_leap(int y);
        if (y <= cal_pkg::SWITCH_YEAR)
            return (y % 4) == 0;
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // gregorian zeller congruence, shifted so that monday is 1
    function automatic logic [2:0] day_of_week(cal_pkg::date_t dt);
        int d;
        int m;
        int y;
        int h;
        d = dt.day;
        m = dt.month;
        y = dt.year;
        if (m < 3)
        begin
            m += 12;
            y -= 1;
        end
        h = d + (13 * (m + 1)) / 5 + y + y / 4 + y / 400 - y / 100;
        h = ((h % 7) + 5) % 7;
        return 3'(h + 1);
    endfunction

    // date loaded by a set command, out-of-range parts pulled back in
    function automatic cal_pkg::date_t corrected_date(int d, int m, int y);
        cal_pkg::date_t r;
        if (y == 0)
            y = 1;
        if (y > cal_pkg::YEAR_MAX)
            y = cal_pkg::YEAR_MAX;
        if (m == 0 || m > 12)
            m = 1;
        if (d == 0 || d > days_in_month(m, y))
            d = 1;
        if (y == cal_pkg::SWITCH_YEAR && m == cal_pkg::MONTH_APR && d < cal_pkg::SWITCH_DAY)
            d = cal_pkg::SWITCH_DAY;
        r.day   = 5'(d);
        r.month = 4'(m);
        r.year  = 14'(y);
        return r;
    endfunction

    // next day, with the calendar switch gap and a hold at the end of range
    function automatic cal_pkg::date_t following_date(cal_pkg::date_t dt);
        cal_pkg::date_t r;
        r = dt;
        if (dt.year == cal_pkg::SWITCH_YEAR && dt.month == cal_pkg::MONTH_MAR
            && dt.day == cal_pkg::DAY_LAST)
        begin
            r.day   = cal_pkg::SWITCH_DAY;
            r.month = cal_pkg::MONTH_APR;
        end
        else if (dt.day < days_in_month(dt.month, dt.year))
            r.day = dt.day + 5'd1;
        else if (dt.month < cal_pkg::MONTH_DEC)
        begin
            r.day   = cal_pkg::DAY_ONE;
            r.month = dt.month + 4'd1;
        end
        else if (dt.year < cal_pkg::YEAR_MAX)
        begin
            r.day   = cal_pkg::DAY_ONE;
            r.month = cal_pkg::MONTH_JAN;
            r.year  = dt.year + 14'd1;
        end
        return r;
    endfunction

    task automatic report(string field, logic [13:0] want, logic [13:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // compare results first, then queue the prediction for a new command
    always @(posedge clk or negedge rst_n)
    begin
        date_result_t want;
        date_result_t next;
        if (!rst_n)
        begin
            cur_date = cal_pkg::DATE_RESET;
            expected_dates.delete();
        end
        else
        begin
            // result side
            if (m_tvalid && m_tready)
            begin
                if (expected_dates.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, actual %0d.%0d.%0d weekday %0d",
                             $time, m_tdata[4:0], m_tdata[8:5], m_tdata[22:9], m_tdata[25:23]);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    checked++;
                    if (m_tdata[4:0] !== want.dt.day)
                        report("day", want.dt.day, m_tdata[4:0]);
                    if (m_tdata[8:5] !== want.dt.month)
                        report("month", want.dt.month, m_tdata[8:5]);
                    if (m_tdata[22:9] !== want.dt.year)
                        report("year", want.dt.year, m_tdata[22:9]);
                    if (m_tdata[25:23] !== want.wd)
                        report("weekday", want.wd, m_tdata[25:23]);
                end
            end
            // command side
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    cal_pkg::CMD_SET:
                        cur_date = corrected_date(s_tdata[4:0], s_tdata[8:5], s_tdata[22:9]);
                    cal_pkg::CMD_ADVANCE:
                    begin
                        if (cur_date.year == cal_pkg::SWITCH_YEAR
                            && cur_date.month == cal_pkg::MONTH_MAR
                            && cur_date.day == cal_pkg::DAY_LAST)
                            switch_hits++;
                        if (cur_date.year == cal_pkg::YEAR_MAX
                            && cur_date.month == cal_pkg::MONTH_DEC
                            && cur_date.day == cal_pkg::DAY_LAST)
                            saturate_hits++;
                        cur_date = following_date(cur_date);
                    end
                    default:
                        ;  // read and the spare code leave the date alone
                endcase
                next.dt = cur_date;
                next.wd = day_of_week(cur_date);
                expected_dates.push_back(next);
            end
        end
        pending = expected_dates.size();
    end

endmodule

// File: tb/sv/tb_calendar_date_counter_top.sv
// ----------------------------------------------------------------------------
// Calendar date counter testbench
// Drives set, advance and read commands into the date counter: a directed
// pass over month ends, leap rules, the 1916 calendar switch, the end of the
// year range and corrected inputs, then random runs of a set date followed by
// advances, mixed with raw sets and reads. Both channels idle at random and
// the receiver holds off once for long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_calendar_date_counter_top;

    localparam int ITEM_TARGET = 450;
    // run limit with room for the random gaps and the long hold
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // new_day[4:0], new_month[8:5], new_year[22:9], zero
    logic [1:0]  s_tuser  = cal_pkg::CMD_READ;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                            // weekday[25:23], zero

    int cycles = 0;
    int sent   = 0;
    int got    = 0;
    int n_set  = 0;
    int n_adv  = 0;
    int n_read = 0;
    int errors;
    int pending;
    int checked;
    int switch_hits;
    int saturate_hits;

    always #5 clk = ~clk;

    calendar_date_counter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cal_date_checker date_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .switch_hits   (switch_hits),
        .saturate_hits (saturate_hits)
    );

    // one command item, after a random gap; returns once accepted
    task automatic send_item(input logic [1:0] cmd, input int d, input int m, input int y);
        int gap;
        gap = $urandom_range(0, 15);
        if ((sent / 40) % 4 == 2)
            gap = 0;   // back-to-back stretch
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, 14'(y), 4'(m), 5'(d)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        case (cmd)
            cal_pkg::CMD_SET:     n_set++;
            cal_pkg::CMD_ADVANCE: n_adv++;
            default:              n_read++;
        endcase
    endtask

    // years weighted toward the switch, the range ends and the century rules
    function automatic int pick_year();
        case ($urandom_range(0, 9))
            0:       return cal_pkg::SWITCH_YEAR;
            1:       return cal_pkg::SWITCH_YEAR - 1 + $urandom_range(0, 2);
            2:       return cal_pkg::YEAR_MAX - $urandom_range(0, 1);
            3:       return 100 * $urandom_range(1, 99);
            4:       return $urandom_range(1, 8);
            default: return $urandom_range(1, cal_pkg::YEAR_MAX);
        endcase
    endfunction

    // run timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, back-to-back stretches and one long hold
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 15);
            if ((got / 50) % 4 == 1)
                stall = 0;
            if (got == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got++;
        end
    end

    // command side and verdict
    initial
    begin
        int pick;
        int y;
        int m;
        int runs;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset date and the spare code
        send_item(cal_pkg::CMD_READ, 0, 0, 0);
        send_item(cal_pkg::CMD_SPARE, 31, 15, 16383);
        // end of range holds
        send_item(cal_pkg::CMD_SET, 31, 12, 9999);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_ADVANCE, 31, 15, 16383);
        // calendar switch and the april after it
        send_item(cal_pkg::CMD_SET, 31, 3, 1916);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 30, 4, 1916);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 5, 4, 1916);
        send_item(cal_pkg::CMD_SET, 13, 4, 1916);
        // zero fields, bad month, day past month end
        send_item(cal_pkg::CMD_SET, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 31, 13, 2020);
        send_item(cal_pkg::CMD_SET, 31, 4, 2021);
        // julian and gregorian february
        send_item(cal_pkg::CMD_SET, 29, 2, 1900);
        send_item(cal_pkg::CMD_SET, 28, 2, 1900);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 29, 2, 2100);
        send_item(cal_pkg::CMD_SET, 28, 2, 2100);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 29, 2, 2000);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        // year rollover and a year past the range
        send_item(cal_pkg::CMD_SET, 31, 12, 1999);
        send_item(cal_pkg::CMD_ADVANCE, 0, 0, 0);
        send_item(cal_pkg::CMD_SET, 15, 15, 10000);

        // random part, mostly a date near a month end followed by advances
        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                y = pick_year();
                m = $urandom_range(1, 12);
                if (pick < 6)
                begin
                    y = cal_pkg::SWITCH_YEAR;
                    m = cal_pkg::MONTH_MAR;
                end
                else if (pick < 10)
                begin
                    y = cal_pkg::YEAR_MAX;
                    m = cal_pkg::MONTH_DEC;
                end
                send_item(cal_pkg::CMD_SET, $urandom_range(26, 31), m, y);
                runs = $urandom_range(1, 8);
                repeat (runs)
                    send_item(cal_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom);
            end
            else if (pick < 72)
                send_item(cal_pkg::CMD_SET, $urandom_range(0, 31), $urandom_range(0, 15),
                          $urandom_range(0, 16383));
            else if (pick < 86)
                send_item(($urandom_range(0, 1) == 0) ? cal_pkg::CMD_READ : cal_pkg::CMD_SPARE,
                          $urandom, $urandom, $urandom);
            else
                send_item(cal_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // drain, then keep watching to catch anything extra
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d commands sent (%0d set, %0d advance, %0d read), %0d results checked",
                 sent, n_set, n_adv, n_read, checked);
        $display("calendar switch crossed %0d times, end of range held %0d times, %0d mismatches",
                 switch_hits, saturate_hits, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
